### rtl/udiv64_pkg.sv
package udiv64_pkg;

    // Fixed width of the payload fields on the ports
    localparam int FIELD_W = 64;

    // Default datapath width (the number of cells in the row)
    localparam int DATA_WIDTH_DEFAULT = 64;

    // Input beat
    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_div_in;

    // Output beat
    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               divide_by_zero;
    } t_div_out;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;   // capture operands, clear partial remainder
        logic step;   // one shift-and-subtract iteration
    } t_cell_ctl;

endpackage

### rtl/udiv64_cell.sv
module udiv64_cell
    import udiv64_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_dvd_bit,   // dividend bit loaded into the quotient slot
    input  logic      i_dvs_bit,   // divisor bit
    input  logic      i_rem_in,    // remainder bit from the lower neighbor
    input  logic      i_q_in,      // quotient bit from the lower neighbor
    input  logic      i_borrow,    // borrow from the lower neighbor
    input  logic      i_take,      // trial subtraction fits
    output logic      o_borrow,
    output logic      o_rem,
    output logic      o_q
);

    logic r_rem;
    logic r_q;
    logic r_dvs;
    logic n_rem;
    logic s_diff;

    // One bit of the trial subtract: shifted remainder minus divisor
    assign s_diff   = i_rem_in ^ r_dvs ^ i_borrow;
    assign o_borrow = (~i_rem_in & r_dvs) | (~(i_rem_in ^ r_dvs) & i_borrow);

    // Keep the difference only when the whole row's subtraction fits
    assign n_rem = i_take ? s_diff : i_rem_in;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= 1'b0;
            r_q   <= i_dvd_bit;
            r_dvs <= i_dvs_bit;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_q   <= i_q_in;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;

endmodule

### rtl/udiv64_row.sv
module udiv64_row
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder
);

    logic [DATA_WIDTH-1:0] s_rem;
    logic [DATA_WIDTH-1:0] s_q;
    logic [DATA_WIDTH:0]   s_borrow;
    logic                  s_take;

    assign s_borrow[0] = 1'b0;

    // Fits if the bit shifted out of the top is set, or no borrow leaves the row
    assign s_take = s_rem[DATA_WIDTH-1] | ~s_borrow[DATA_WIDTH];

    // Row of bit cells: remainder and quotient shift up one cell per step
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        logic s_rem_in;
        logic s_q_in;

        if (g == 0) begin : g_low
            // Lowest cell takes the next dividend bit and the new quotient bit
            assign s_rem_in = s_q[DATA_WIDTH-1];
            assign s_q_in   = s_take;
        end else begin : g_mid
            assign s_rem_in = s_rem[g-1];
            assign s_q_in   = s_q[g-1];
        end

        udiv64_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_dvd_bit (i_dividend[g]),
            .i_dvs_bit (i_divisor[g]),
            .i_rem_in  (s_rem_in),
            .i_q_in    (s_q_in),
            .i_borrow  (s_borrow[g]),
            .i_take    (s_take),
            .o_borrow  (s_borrow[g+1]),
            .o_rem     (s_rem[g]),
            .o_q       (s_q[g])
        );
    end

    assign o_quotient  = s_q;
    assign o_remainder = s_rem;

endmodule

### rtl/unsigned_divider_64.sv
// Unsigned divider, 64-bit ports, DATA_WIDTH-bit datapath.
//
// Input channel: i_in_valid / o_in_ready with i_in_data (dividend, divisor).
// Output channel: o_out_valid / i_out_ready with o_out_data (quotient,
// remainder, divide_by_zero). A beat moves when valid and ready are both high.
// Operand bits above DATA_WIDTH are ignored; result bits above it are zero.
//
// One item at a time. After an input beat the row of DATA_WIDTH bit cells
// runs DATA_WIDTH shift-and-subtract steps, one per cycle, then the result
// is written to the output register. o_in_ready rises in the same cycle as
// o_out_valid, so the next item is accepted only after the last one has
// finished its steps in the one-bit-per-cycle iteration of the cell row.
// A zero divisor gives a quotient of all ones, a remainder of zero and
// divide_by_zero set, with the same timing.
// The output register holds its beat while i_out_ready is low; a new item can
// be accepted and computed meanwhile, and it waits at the end of its steps
// until the output register is free.
// Reset (i_rst_n low, synchronous) drops o_out_valid and returns to idle.
module unsigned_divider_64
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_div_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_div_out o_out_data
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_dbz;
    logic                  r_out_valid;
    t_div_out              r_out;

    t_cell_ctl             s_ctl;
    logic                  s_in_beat;
    logic                  s_done;
    logic [DATA_WIDTH-1:0] s_quotient;
    logic [DATA_WIDTH-1:0] s_remainder;

    assign o_in_ready  = (r_state == S_IDLE);
    assign s_in_beat   = i_in_valid && o_in_ready;
    // Last step finished and the output register can take the result
    assign s_done      = (r_state == S_RUN) && (r_cnt == '0) &&
                         (!r_out_valid || i_out_ready);

    assign s_ctl.load  = s_in_beat;
    assign s_ctl.step  = (r_state == S_RUN) && (r_cnt != '0);

    udiv64_row #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_row (
        .i_clk       (i_clk),
        .i_ctl       (s_ctl),
        .i_dividend  (i_in_data.dividend[DATA_WIDTH-1:0]),
        .i_divisor   (i_in_data.divisor[DATA_WIDTH-1:0]),
        .o_quotient  (s_quotient),
        .o_remainder (s_remainder)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_in_beat) begin
                        r_state <= S_RUN;
                        r_cnt   <= CNT_W'(DATA_WIDTH);
                        r_dbz   <= (i_in_data.divisor[DATA_WIDTH-1:0] == '0);
                    end
                end
                S_RUN: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else if (s_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (s_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Result payload, no reset needed
        if (s_done) begin
            r_out.divide_by_zero <= r_dbz;
            r_out.quotient       <= r_dbz ? FIELD_W'({DATA_WIDTH{1'b1}})
                                          : FIELD_W'(s_quotient);
            r_out.remainder      <= r_dbz ? '0 : FIELD_W'(s_remainder);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // No second item enters while one is in the row
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_beat |=> !o_in_ready)
        else $error("input accepted while busy");

    // A new result only appears at the end of a run
    a_rise_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RUN) && $past(r_cnt == '0))
        else $error("result produced outside the end of a run");

    // The row keeps iterating until its step count runs out
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt != '0) |=> (r_state == S_RUN))
        else $error("run left before all steps were done");

    // Divide by zero reports the defined result
    a_dbz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.divide_by_zero) |->
            (o_out_data.remainder == '0) &&
            (o_out_data.quotient == FIELD_W'({DATA_WIDTH{1'b1}})))
        else $error("wrong divide-by-zero result");

    // Results never carry bits above the datapath width
    a_result_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.quotient  == FIELD_W'(o_out_data.quotient[DATA_WIDTH-1:0])) &&
            (o_out_data.remainder == FIELD_W'(o_out_data.remainder[DATA_WIDTH-1:0])))
        else $error("result wider than the datapath");

endmodule

### sim/udiv64_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the divider, predicts each quotient and remainder
// and compares them against the output beats in order.
module udiv64_result_checker
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_div_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_div_out i_out_data,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked,
    output int       o_zero_div
);

    // Operands kept with their predicted result for readable reports
    typedef struct {
        t_div_in  operands;
        t_div_out result;
    } t_division_due;

    t_division_due divisions_due[$];
    int            fail_count = 0;
    int            checked    = 0;
    int            zero_div   = 0;

    // Shift-and-subtract division at DATA_WIDTH bits
    function automatic t_div_out divide_restoring(t_div_in operands);
        bit [FIELD_W-1:0] width_mask;
        bit [FIELD_W-1:0] top_bit;
        bit [FIELD_W-1:0] partial_rem;
        bit [FIELD_W-1:0] shifted_den;
        bit [FIELD_W-1:0] quo;
        bit [FIELD_W-1:0] qbit;
        t_div_out         res;
        width_mask  = {FIELD_W{1'b1}} >> (FIELD_W - DATA_WIDTH);
        top_bit     = 64'd1 << (DATA_WIDTH - 1);
        partial_rem = operands.dividend & width_mask;
        shifted_den = operands.divisor & width_mask;
        quo         = '0;
        qbit        = 64'd1;
        if (shifted_den == '0) begin
            res.quotient       = width_mask;
            res.remainder      = '0;
            res.divide_by_zero = 1'b1;
            return res;
        end
        // normalize until the divisor's top bit is set
        while ((shifted_den & top_bit) == '0) begin
            shifted_den = (shifted_den << 1) & width_mask;
            qbit        = qbit << 1;
        end
        // one quotient bit per step, from the top down
        while (qbit != '0) begin
            if (shifted_den <= partial_rem) begin
                partial_rem = partial_rem - shifted_den;
                quo         = quo | qbit;
            end
            shifted_den = shifted_den >> 1;
            qbit        = qbit >> 1;
        end
        res.quotient       = quo & width_mask;
        res.remainder      = partial_rem & width_mask;
        res.divide_by_zero = 1'b0;
        return res;
    endfunction

    function automatic void note_failure();
        fail_count++;
    endfunction

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_division_due due;
        if (i_rst_n) begin
            // input beat: queue its prediction
            if (i_in_valid && i_in_ready) begin
                due.operands = i_in_data;
                due.result   = divide_restoring(i_in_data);
                divisions_due.push_back(due);
            end
            // output beat: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (divisions_due.size() == 0) begin
                    note_failure();
                    $display("%0t: expected no beat, got q=%h r=%h dz=%b", $time,
                             i_out_data.quotient, i_out_data.remainder,
                             i_out_data.divide_by_zero);
                end else begin
                    due = divisions_due.pop_front();
                    checked++;
                    if (due.result.divide_by_zero)
                        zero_div++;
                    if (i_out_data !== due.result) begin
                        note_failure();
                        $display("%0t: %h / %h mismatch", $time,
                                 due.operands.dividend, due.operands.divisor);
                        if (i_out_data.quotient !== due.result.quotient)
                            $display("    quotient: expected %h, got %h",
                                     due.result.quotient, i_out_data.quotient);
                        if (i_out_data.remainder !== due.result.remainder)
                            $display("    remainder: expected %h, got %h",
                                     due.result.remainder, i_out_data.remainder);
                        if (i_out_data.divide_by_zero !== due.result.divide_by_zero)
                            $display("    divide_by_zero: expected %b, got %b",
                                     due.result.divide_by_zero,
                                     i_out_data.divide_by_zero);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= divisions_due.size();
        o_checked    <= checked;
        o_zero_div   <= zero_div;
    end

    // Predictions still waiting when the run ends are failures too
    function automatic int leftover_count();
        return divisions_due.size();
    endfunction

endmodule

### sim/tb_unsigned_divider_64.sv
`timescale 1ns / 100ps

module tb_unsigned_divider_64
    import udiv64_pkg::*;
();

    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 2000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_div_in  in_data;
    logic     out_valid;
    logic     out_ready;
    t_div_out out_data;

    int fail_count;
    int pending;
    int checked;
    int zero_div;
    int idle_cycles;

    unsigned_divider_64 i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    udiv64_result_checker #(
        .DATA_WIDTH(DATA_WIDTH_DEFAULT)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_zero_div  (zero_div)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("** unsigned_divider_64: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic bit [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Random word with a random number of leading zeros
    function automatic bit [63:0] random_scaled();
        return random_word() >> $urandom_range(0, 63);
    endfunction

    // Present one beat at the falling edge and hold it until accepted
    task automatic send_division(input bit [63:0] dividend, input bit [63:0] divisor);
        in_valid         <= 1'b1;
        in_data.dividend <= dividend;
        in_data.divisor  <= divisor;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Sender gap between bursts; valid drops only when the gap is nonzero
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic send_random_division();
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] t;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            a = random_scaled();
            b = random_scaled();
        end else if (pick < 50) begin
            a = random_word();
            b = random_scaled();
        end else if (pick < 65) begin
            // exact multiple plus a remainder below the divisor
            b = random_word() >> $urandom_range(32, 63);
            if (b == 0)
                b = 64'd1;
            t = random_word() >> $urandom_range(32, 63);
            a = t * b + (random_word() % b);
        end else if (pick < 75) begin
            // divisor above dividend
            a = random_scaled();
            b = random_scaled();
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            if (a == b)
                b = b + 1;
        end else if (pick < 83) begin
            b = random_scaled();
            a = b + 64'($signed($urandom_range(0, 2)) - 1);
        end else if (pick < 90) begin
            a = random_scaled();
            b = '0;
        end else if (pick < 95) begin
            a = random_word();
            b = 64'd1 << $urandom_range(0, 63);
        end else begin
            a = random_word();
            b = 64'($urandom_range(1, 15));
        end
        send_division(a, b);
    endtask

    // Receiver: rotates a ready pattern, switching pattern now and then
    initial begin
        bit [31:0] ready_pattern;
        int        hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '1;
                1: ready_pattern = $urandom | 32'h1;
                2: ready_pattern = ($urandom & $urandom) | 32'h1;
                default: ready_pattern = 32'h1;
            endcase
            hold = $urandom_range(64, 600);
            repeat (hold) begin
                @(negedge clk);
                out_ready     <= ready_pattern[0];
                ready_pattern  = {ready_pattern[0], ready_pattern[31:1]};
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int burst_left;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes and the special cases
        send_division(64'd0, 64'd0);
        send_division(64'd0, 64'd1);
        send_division('1, 64'd0);
        send_division(64'd12345, 64'd0);
        send_division('1, '1);
        send_division('1, 64'd1);
        send_division(64'd1, '1);
        send_division(64'd1, 64'd1);
        send_division(64'h8000_0000_0000_0000, 64'd1);
        send_division(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_division('1, 64'h8000_0000_0000_0000);
        send_division(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_division('1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_division('1, 64'd3);
        send_division(64'd100, 64'd7);
        send_division(64'd7, 64'd100);
        send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_division(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
        send_division(64'h0000_0001_0000_0000, 64'h0000_0000_0000_0002);
        send_division(64'hDEAD_BEEF_CAFE_F00D, 64'h0000_0000_0001_0001);
        sender_gap(3);

        // random: bursts with gaps between them
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40));
                burst_left = $urandom_range(1, 8);
            end
            send_random_division();
            burst_left--;
        end
        in_valid <= 1'b0;

        // drain, then allow late stray beats to show up
        while (pending != 0)
            @(negedge clk);
        repeat (DATA_WIDTH_DEFAULT + 8) @(negedge clk);

        $display("Checked %0d divisions, %0d with a zero divisor, under random sender gaps",
                 checked, zero_div);
        $display("and receiver stalls; %0d predictions left over.", i_checker.leftover_count());
        if (fail_count == 0 && i_checker.leftover_count() == 0)
            $display("** unsigned_divider_64: PASSED **");
        else
            $display("** unsigned_divider_64: FAILED **");
        $finish;
    end

endmodule
